### rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and constants of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} jsu_kind_t;

	// Error codes carried with an error result.
	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_EXP_STRING = 3'd1,
		ERR_UNTERM_ESC = 3'd2,
		ERR_BAD_UNI    = 3'd3,
		ERR_BAD_ESC    = 3'd4,
		ERR_UNTERM_STR = 3'd5
	} jsu_err_t;

	// Scanner modes.
	typedef enum logic [1:0] {
		MODE_WAIT = 2'd0,
		MODE_STR  = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} jsu_mode_t;

	// Input opcode values.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Most results caused by one input item.
	localparam int MAX_RESULTS = 3;

	// One result item.
	typedef struct packed {
		jsu_kind_t  kind;
		logic [7:0] data;
		jsu_err_t   err;
	} jsu_res_t;

	// All results of one input item, entry 0 goes out first.
	typedef struct packed {
		logic [1:0]                 count;
		jsu_res_t [MAX_RESULTS-1:0] item;
	} jsu_batch_t;

	// Characters that the scanner recognizes.
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	// UTF-8 limits and lead and trail marks.
	localparam logic [15:0] CP_MAX1   = 16'h007F;
	localparam logic [15:0] CP_MAX2   = 16'h07FF;
	localparam logic [7:0]  LEAD2     = 8'hC0;
	localparam logic [7:0]  LEAD3     = 8'hE0;
	localparam logic [7:0]  TRAIL     = 8'h80;

endpackage

### rtl/core/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Scanner state and decode logic: turns one input byte into zero to three
// result items and updates the scan mode, digit count and code point.
// ----------------------------------------------------------------------------
module jsu_decode
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       opcode,
	input  logic [7:0] data_byte,
	output jsu_batch_t batch
);

	jsu_mode_t   mode_q, mode_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [15:0] acc_q, acc_d;

	logic        at_end;
	logic        nib_ok;
	logic [3:0]  nib;
	logic [15:0] acc_shift;

	assign at_end = (opcode == OP_END);

	// Hex digit value of the input byte.
	always_comb begin
		nib_ok = 1'b1;
		nib    = 4'd0;
		if (data_byte inside {[8'h30:8'h39]}) begin
			nib = data_byte[3:0];
		end else if (data_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			nib = data_byte[3:0] + 4'd9;
		end else begin
			nib_ok = 1'b0;
		end
	end

	assign acc_shift = {acc_q[11:0], nib};

	// Next state and results for the current byte.
	always_comb begin
		mode_d      = mode_q;
		hex_cnt_d   = hex_cnt_q;
		acc_d       = acc_q;
		batch.count = 2'd0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			batch.item[i] = '{kind: KIND_BYTE, data: 8'h00, err: ERR_NONE};
		end
		case (mode_q)
			MODE_WAIT: begin
				if (at_end || data_byte != CH_QUOTE) begin
					batch.count   = 2'd1;
					batch.item[0] = '{kind: KIND_ERR, data: 8'h00, err: ERR_EXP_STRING};
				end else begin
					mode_d = MODE_STR;
				end
			end
			MODE_STR: begin
				if (at_end) begin
					mode_d        = MODE_WAIT;
					batch.count   = 2'd1;
					batch.item[0] = '{kind: KIND_ERR, data: 8'h00, err: ERR_UNTERM_STR};
				end else if (data_byte == CH_QUOTE) begin
					mode_d        = MODE_WAIT;
					batch.count   = 2'd1;
					batch.item[0] = '{kind: KIND_DONE, data: 8'h00, err: ERR_NONE};
				end else if (data_byte == CH_BSL) begin
					mode_d = MODE_ESC;
				end else begin
					batch.count   = 2'd1;
					batch.item[0] = '{kind: KIND_BYTE, data: data_byte, err: ERR_NONE};
				end
			end
			MODE_ESC: begin
				if (at_end) begin
					mode_d        = MODE_WAIT;
					batch.count   = 2'd1;
					batch.item[0] = '{kind: KIND_ERR, data: 8'h00, err: ERR_UNTERM_ESC};
				end else begin
					mode_d        = MODE_STR;
					batch.count   = 2'd1;
					batch.item[0] = '{kind: KIND_BYTE, data: data_byte, err: ERR_NONE};
					case (data_byte)
						CH_QUOTE, CH_BSL, CH_SLASH: ;
						CH_B: batch.item[0].data = 8'h08;
						CH_F: batch.item[0].data = 8'h0C;
						CH_N: batch.item[0].data = 8'h0A;
						CH_R: batch.item[0].data = 8'h0D;
						CH_T: batch.item[0].data = 8'h09;
						CH_U: begin
							mode_d      = MODE_HEX;
							hex_cnt_d   = 2'd0;
							acc_d       = 16'h0000;
							batch.count = 2'd0;
						end
						default: begin
							mode_d        = MODE_WAIT;
							batch.item[0] = '{kind: KIND_ERR, data: 8'h00,
								err: ERR_BAD_ESC};
						end
					endcase
				end
			end
			default: begin
				if (at_end || !nib_ok) begin
					mode_d        = MODE_WAIT;
					hex_cnt_d     = 2'd0;
					acc_d         = 16'h0000;
					batch.count   = 2'd1;
					batch.item[0] = '{kind: KIND_ERR, data: 8'h00, err: ERR_BAD_UNI};
				end else if (hex_cnt_q == 2'd3) begin
					// Fourth digit: write the code point as UTF-8.
					mode_d    = MODE_STR;
					hex_cnt_d = 2'd0;
					acc_d     = 16'h0000;
					if (acc_shift <= CP_MAX1) begin
						batch.count        = 2'd1;
						batch.item[0].data = acc_shift[7:0];
					end else if (acc_shift <= CP_MAX2) begin
						batch.count        = 2'd2;
						batch.item[0].data = LEAD2 | {3'b000, acc_shift[10:6]};
						batch.item[1].data = TRAIL | {2'b00, acc_shift[5:0]};
					end else begin
						batch.count        = 2'd3;
						batch.item[0].data = LEAD3 | {4'h0, acc_shift[15:12]};
						batch.item[1].data = TRAIL | {2'b00, acc_shift[11:6]};
						batch.item[2].data = TRAIL | {2'b00, acc_shift[5:0]};
					end
				end else begin
					acc_d     = acc_shift;
					hex_cnt_d = hex_cnt_q + 2'd1;
				end
			end
		endcase
	end

	// Scanner state registers, updated once per decoded byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_WAIT;
			hex_cnt_q <= 2'd0;
			acc_q     <= 16'h0000;
		end else if (step) begin
			mode_q    <= mode_d;
			hex_cnt_q <= hex_cnt_d;
			acc_q     <= acc_d;
		end
	end

endmodule

### rtl/core/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming JSON string unescaper with UTF-8 output of unicode escapes.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata                        tuser      tlast
//  s_axis    in         [7:0] data_byte              opcode     -
//  m_axis    out        [7:0] out_byte,              out_kind   last
//                       [10:8] error_code
//
// An input transfer goes into an input register and is decoded once the
// three-entry result register can take its results. One result leaves
// per cycle unless the receiver stalls. A unicode escape writing two or
// three bytes holds the next input until all but the last have left; the
// input register accepts while the last result is taken. Reset returns
// the scanner to waiting for an opening quote and empties both registers.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
	import jsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code
	output logic [1:0]  m_tuser,   // [1:0] out_kind
	output logic        m_tlast    // last
);

	logic       v_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	jsu_batch_t                 batch;
	jsu_res_t [MAX_RESULTS-1:0] res_q;
	logic [1:0]                 cnt_q;

	logic pop;
	logic advance;
	logic step;

	// Handshake control.
	assign pop      = m_tvalid && m_tready;
	assign advance  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);
	assign step     = v_s1 && advance;
	assign s_tready = !v_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	jsu_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.opcode    (op_s1),
		.data_byte (byte_s1),
		.batch     (batch)
	);

	// Result register: load a whole batch, then shift one out per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (step) begin
			cnt_q <= batch.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= batch.item;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	// Output fields from the head entry.
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {5'b00000, res_q[0].err, res_q[0].data};
	assign m_tuser  = res_q[0].kind;
	assign m_tlast  = (cnt_q == 2'd1);

endmodule

### sim/tb_json_string_unescape_utf8.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8
// Self-checking testbench of the streaming JSON string unescaper. A short
// directed part covers the waiting state, the extremes of the text bytes,
// a line feed escape, UTF-8 output of unicode escapes and every error
// exit. Random strings, mostly well formed and partly broken or noisy,
// follow. A behavioral decoder in the testbench predicts every result,
// and the checker compares each result transfer with the oldest
// prediction. Both sides of the block stall at random.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8;
	import jsu_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 400;

	// One expected result transfer.
	typedef struct {
		jsu_kind_t  kind;
		logic [7:0] data;
		jsu_err_t   err;
		logic       last;
	} decoded_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
	logic        s_tuser = OP_BYTE; // [0] opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [7:0] out_byte, [10:8] error_code
	logic [1:0]  m_tuser;           // [1:0] out_kind
	logic        m_tlast;           // last

	// Decoder state mirrored by the testbench.
	jsu_mode_t   tb_mode = MODE_WAIT;
	logic [1:0]  tb_hex_count = 2'd0;
	logic [15:0] tb_code_point = 16'h0000;

	decoded_result_t expected_results[$];
	decoded_result_t want;
	int error_count = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int rx_stall = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;

	json_string_unescape_utf8 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_json_string_unescape_utf8: done, errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got,
			exp_val);
		error_count++;
	endtask

	// Hex digit value of a character, or -1 when it is not a hex digit.
	function automatic int digit_value(input logic [7:0] b);
		if (b >= "0" && b <= "9")
			return int'(b) - int'("0");
		if (b >= "a" && b <= "f")
			return int'(b) - int'("a") + 10;
		if (b >= "A" && b <= "F")
			return int'(b) - int'("A") + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input int nib, input bit upper);
		if (nib < 10)
			return 8'(int'("0") + nib);
		return 8'((upper ? int'("A") : int'("a")) + nib - 10);
	endfunction

	// Single-letter escapes: returns 1 and the decoded byte for a known letter.
	function automatic bit simple_escape(input logic [7:0] b, output logic [7:0] mapped);
		mapped = 8'h00;
		case (b)
			CH_QUOTE: mapped = CH_QUOTE;
			CH_BSL:   mapped = CH_BSL;
			CH_SLASH: mapped = CH_SLASH;
			CH_B:     mapped = 8'h08;
			CH_F:     mapped = 8'h0C;
			CH_N:     mapped = 8'h0A;
			CH_R:     mapped = 8'h0D;
			CH_T:     mapped = 8'h09;
			default:  return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic logic [7:0] escape_letter(input int idx);
		case (idx)
			0:       return CH_QUOTE;
			1:       return CH_BSL;
			2:       return CH_SLASH;
			3:       return CH_B;
			4:       return CH_F;
			5:       return CH_N;
			6:       return CH_R;
			default: return CH_T;
		endcase
	endfunction

	// Advances the mirrored decoder by one accepted input and queues its results.
	task automatic decode_step(input logic op, input logic [7:0] b);
		decoded_result_t batch [MAX_RESULTS];
		int count;
		int nib;
		int i;
		logic [7:0] mapped;
		logic [15:0] cp;
		jsu_err_t fault;
		count = 0;
		fault = ERR_NONE;
		case (tb_mode)
			MODE_WAIT: begin
				if (op == OP_END || b != CH_QUOTE)
					fault = ERR_EXP_STRING;
				else
					tb_mode = MODE_STR;
			end
			MODE_STR: begin
				if (op == OP_END) begin
					fault = ERR_UNTERM_STR;
				end else if (b == CH_QUOTE) begin
					tb_mode = MODE_WAIT;
					batch[0] = '{KIND_DONE, 8'h00, ERR_NONE, 1'b0};
					count = 1;
				end else if (b == CH_BSL) begin
					tb_mode = MODE_ESC;
				end else begin
					batch[0] = '{KIND_BYTE, b, ERR_NONE, 1'b0};
					count = 1;
				end
			end
			MODE_ESC: begin
				if (op == OP_END) begin
					fault = ERR_UNTERM_ESC;
				end else if (b == CH_U) begin
					tb_mode = MODE_HEX;
					tb_hex_count = 2'd0;
					tb_code_point = 16'h0000;
				end else if (simple_escape(b, mapped)) begin
					tb_mode = MODE_STR;
					batch[0] = '{KIND_BYTE, mapped, ERR_NONE, 1'b0};
					count = 1;
				end else begin
					fault = ERR_BAD_ESC;
				end
			end
			default: begin
				nib = digit_value(b);
				if (op == OP_END || nib < 0) begin
					fault = ERR_BAD_UNI;
				end else begin
					cp = {tb_code_point[11:0], nib[3:0]};
					if (tb_hex_count == 2'd3) begin
						// Fourth digit: write the code point as UTF-8.
						tb_mode = MODE_STR;
						tb_hex_count = 2'd0;
						tb_code_point = 16'h0000;
						if (cp <= CP_MAX1) begin
							batch[0] = '{KIND_BYTE, cp[7:0], ERR_NONE, 1'b0};
							count = 1;
						end else if (cp <= CP_MAX2) begin
							batch[0] = '{KIND_BYTE, LEAD2 | {3'b000, cp[10:6]}, ERR_NONE, 1'b0};
							batch[1] = '{KIND_BYTE, TRAIL | {2'b00, cp[5:0]}, ERR_NONE, 1'b0};
							count = 2;
						end else begin
							batch[0] = '{KIND_BYTE, LEAD3 | {4'b0000, cp[15:12]}, ERR_NONE, 1'b0};
							batch[1] = '{KIND_BYTE, TRAIL | {2'b00, cp[11:6]}, ERR_NONE, 1'b0};
							batch[2] = '{KIND_BYTE, TRAIL | {2'b00, cp[5:0]}, ERR_NONE, 1'b0};
							count = 3;
						end
					end else begin
						tb_code_point = cp;
						tb_hex_count = tb_hex_count + 2'd1;
					end
				end
			end
		endcase
		// Every error drops the scan back to waiting for a quote.
		if (fault != ERR_NONE) begin
			tb_mode = MODE_WAIT;
			tb_hex_count = 2'd0;
			tb_code_point = 16'h0000;
			batch[0] = '{KIND_ERR, 8'h00, fault, 1'b0};
			count = 1;
		end
		for (i = 0; i < count; i++) begin
			batch[i].last = (i == count - 1);
			expected_results.insert(expected_results.size(), batch[i]);
		end
	endtask

	// Offers one input transfer after a random gap and waits until it is taken.
	task automatic send_item(input logic op, input logic [7:0] b);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_step(op, b);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(OP_BYTE, b);
	endtask

	// End of text carries a random, ignored data byte.
	task automatic send_end();
		send_item(OP_END, 8'($urandom_range(0, 255)));
	endtask

	// Sends a backslash, 'u' and the first digits of a code point in random case.
	task automatic send_unicode(input logic [15:0] cp, input int digits);
		int k;
		send_byte(CH_BSL);
		send_byte(CH_U);
		for (k = 3; k > 3 - digits; k--)
			send_byte(hex_char(int'((cp >> (4 * k)) & 16'h000F),
				1'($urandom_range(0, 1))));
	endtask

	// Result checker and receiver stall.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", int'(m_tdata), 0);
			end else begin
				want = expected_results.pop_front();
				if (m_tuser != want.kind)
					report_mismatch("out_kind", int'(m_tuser), int'(want.kind));
				if (m_tdata[7:0] != want.data)
					report_mismatch("out_byte", int'(m_tdata[7:0]), int'(want.data));
				if (m_tdata[10:8] != want.err)
					report_mismatch("error_code", int'(m_tdata[10:8]), int'(want.err));
				if (m_tlast != want.last)
					report_mismatch("last", int'(m_tlast), int'(want.last));
			end
			rx_stall = rx_idle_on ? $urandom_range(0, 19) : 0;
		end
		if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Text outside a string and end of text while waiting.
	task automatic test_outside_string();
		send_byte("a");
		send_end();
	endtask

	// Byte extremes, a line feed escape, a three-byte escape in mixed case, a two-byte escape, close.
	task automatic test_string_body();
		send_byte(CH_QUOTE);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(CH_BSL);
		send_byte(CH_N);
		send_byte(CH_BSL);
		send_byte(CH_U);
		send_byte("F");
		send_byte("f");
		send_byte("f");
		send_byte("F");
		send_unicode(16'h07FF, 4);
		send_byte(CH_QUOTE);
	endtask

	// Each way a string can break off.
	task automatic test_error_exits();
		send_byte(CH_QUOTE);
		send_byte(CH_BSL);
		send_byte("x");
		send_byte(CH_QUOTE);
		send_byte(CH_BSL);
		send_end();
		send_byte(CH_QUOTE);
		send_unicode(16'h0000, 1);
		send_byte("g");
		send_byte(CH_QUOTE);
		send_unicode(16'h0000, 0);
		send_end();
		send_byte(CH_QUOTE);
		send_end();
	endtask

	function automatic logic [15:0] pick_code_point();
		int lo;
		int hi;
		case ($urandom_range(0, 2))
			0: begin
				lo = 0;
				hi = int'(CP_MAX1);
			end
			1: begin
				lo = int'(CP_MAX1) + 1;
				hi = int'(CP_MAX2);
			end
			default: begin
				lo = int'(CP_MAX2) + 1;
				hi = 16'hFFFF;
			end
		endcase
		// Favor the edges of each UTF-8 length class.
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom_range(0, 1) ? hi : lo);
		return 16'($urandom_range(hi, lo));
	endfunction

	// Random strings: mostly well formed, some broken, some noise between them.
	task automatic test_random_strings(input int target);
		int stop_at;
		int n;
		int k;
		logic [7:0] b;
		logic [7:0] mapped;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < 12) begin
				// Noise outside a string.
				n = $urandom_range(1, 3);
				for (k = 0; k < n; k++) begin
					if ($urandom_range(0, 3) == 0)
						send_end();
					else
						send_byte(8'($urandom_range(0, 255)));
				end
			end else begin
				send_byte(CH_QUOTE);
				n = $urandom_range(0, 8);
				for (k = 0; k < n; k++) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: begin
							b = 8'($urandom_range(0, 255));
							if (b == CH_QUOTE || b == CH_BSL)
								b = b ^ 8'h01;
							send_byte(b);
						end
						5, 6: begin
							send_byte(CH_BSL);
							send_byte(escape_letter($urandom_range(0, 7)));
						end
						default: send_unicode(pick_code_point(), 4);
					endcase
				end
				case ($urandom_range(0, 9))
					6: send_end();
					7: begin
						send_byte(CH_BSL);
						send_end();
					end
					8: begin
						send_unicode(pick_code_point(), $urandom_range(0, 3));
						if ($urandom_range(0, 1)) begin
							send_end();
						end else begin
							do
								b = 8'($urandom_range(0, 255));
							while (digit_value(b) >= 0);
							send_byte(b);
						end
					end
					9: begin
						send_byte(CH_BSL);
						do
							b = 8'($urandom_range(0, 255));
						while (simple_escape(b, mapped) || b == CH_U);
						send_byte(b);
					end
					default: send_byte(CH_QUOTE);
				endcase
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_outside_string();
		test_string_body();
		test_error_exits();
		test_random_strings(RANDOM_ITEMS);
		s_tvalid <= 1'b0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_json_string_unescape_utf8: done, clean");
		else
			$display("tb_json_string_unescape_utf8: done, errors");
		$finish;
	end

endmodule

### json_string_unescape_utf8.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_decode.sv
rtl/core/json_string_unescape_utf8.sv
sim/tb_json_string_unescape_utf8.sv
